// File: design/ukst_pkg.sv
`timescale 1ns / 1ps

package ukst_pkg;

    localparam int KEY_W        = 32;
    localparam int SLOT_W       = 6;
    localparam int OCC_W        = 7;
    localparam int CAPACITY_DEF = 64;
    localparam int ENTRY_W      = KEY_W + 1;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_SEARCH  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [KEY_W-1:0]  key;
        logic signed [KEY_W-1:0]  new_key;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    typedef struct packed {
        logic hit;
        logic new_hit;
        logic free;
    } scan_flags_t;

endpackage

// File: design/ukst_ram.sv
`timescale 1ns / 1ps

module ukst_ram #(
    parameter int WIDTH = ukst_pkg::ENTRY_W,
    parameter int DEPTH = ukst_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/ukst_match.sv
`timescale 1ns / 1ps

module ukst_match #(
    parameter int IDX_W = $clog2(ukst_pkg::CAPACITY_DEF)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           rd_vld,
    input  logic [IDX_W-1:0]               rd_idx,
    input  logic [ukst_pkg::ENTRY_W-1:0]   rd_entry,
    input  logic [ukst_pkg::KEY_W-1:0]     key,
    input  logic [ukst_pkg::KEY_W-1:0]     new_key,
    output ukst_pkg::scan_flags_t          flags,
    output logic [IDX_W-1:0]               hit_idx,
    output logic [IDX_W-1:0]               free_idx
);

    ukst_pkg::scan_flags_t     flags_reg, flags_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;
    logic                      ent_valid;
    logic [ukst_pkg::KEY_W-1:0] ent_key;

    assign ent_valid = rd_entry[ukst_pkg::KEY_W];
    assign ent_key   = rd_entry[ukst_pkg::KEY_W-1:0];

    always_comb
    begin
        flags_next    = flags_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else if (rd_vld)
        begin
            if (ent_valid && ent_key == key && !flags_reg.hit)
            begin
                flags_next.hit = 1'b1;
                hit_idx_next   = rd_idx;
            end
            if (ent_valid && ent_key == new_key)
            begin
                flags_next.new_hit = 1'b1;
            end
            if (!ent_valid && !flags_reg.free)
            begin
                flags_next.free = 1'b1;
                free_idx_next   = rd_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign flags    = flags_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;

endmodule

// File: design/unique_key_set_table.sv
`timescale 1ns / 1ps
// a request is served by one table scan, one slot read per cycle through a
// single ram read port, then a commit that may write the table and registers the response
// only one request is in flight; a stalled response holds the next commit
// until it is taken
// reset: a clearing pass marks every slot empty; requests are stalled until
// it is done, key count resets to zero

module unique_key_set_table #(
    parameter int CAPACITY = ukst_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ukst_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ukst_pkg::rsp_t  rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    ukst_pkg::req_t         req_reg, req_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    ukst_pkg::rsp_t         rsp_reg, rsp_next;

    logic                   accept;
    logic                   issuing;
    logic                   commit_go;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ukst_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ukst_pkg::ENTRY_W-1:0] ram_rdata;

    ukst_pkg::scan_flags_t  flags;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       free_idx;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign issuing   = (cnt_reg != CNT_W'(CAPACITY));
    assign commit_go = (state_reg == ST_COMMIT) && !(rsp_valid_reg && rsp_stall);
    assign ram_raddr = cnt_reg[IDX_W-1:0];

    ukst_ram #(
        .WIDTH (ukst_pkg::ENTRY_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ukst_match #(
        .IDX_W (IDX_W)
    ) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .rd_vld   (rd_vld_reg),
        .rd_idx   (rd_idx_reg),
        .rd_entry (ram_rdata),
        .key      (req_reg.key),
        .new_key  (req_reg.new_key),
        .flags    (flags),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rd_vld_next    = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[IDX_W-1:0];
        ram_wdata      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    rsp_next.ok   = 1'b0;
                    rsp_next.slot = '0;
                    unique case (req_reg.op)
                        ukst_pkg::OP_INSERT:
                        begin
                            if (!flags.hit && flags.free)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = free_idx;
                                ram_wdata     = {1'b1, req_reg.key};
                                count_next    = count_reg + 1'b1;
                                rsp_next.ok   = 1'b1;
                                rsp_next.slot = ukst_pkg::SLOT_W'(free_idx);
                            end
                        end
                        ukst_pkg::OP_REMOVE:
                        begin
                            if (flags.hit)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = hit_idx;
                                ram_wdata     = {1'b0, req_reg.key};
                                count_next    = count_reg - 1'b1;
                                rsp_next.ok   = 1'b1;
                                rsp_next.slot = ukst_pkg::SLOT_W'(hit_idx);
                            end
                        end
                        ukst_pkg::OP_REPLACE:
                        begin
                            if (flags.hit && !flags.new_hit)
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = hit_idx;
                                ram_wdata     = {1'b1, req_reg.new_key};
                                rsp_next.ok   = 1'b1;
                                rsp_next.slot = ukst_pkg::SLOT_W'(hit_idx);
                            end
                        end
                        ukst_pkg::OP_SEARCH:
                        begin
                            if (flags.hit)
                            begin
                                rsp_next.ok   = 1'b1;
                                rsp_next.slot = ukst_pkg::SLOT_W'(hit_idx);
                            end
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                    rsp_next.occupancy = ukst_pkg::OCC_W'(count_next);
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        rd_idx_reg <= ram_raddr;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
